@@ src/tlip_pkg.sv @@
// package for the telnet line input parser
// request and response payload types, telnet codes, parser modes and fsm states
// no dependencies
package tlip_pkg;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic       last;
   } rsp_payload_type;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_OPEN = 1'b1;

   localparam logic [1:0] KIND_NEG    = 2'd0;
   localparam logic [1:0] KIND_ECHO   = 2'd1;
   localparam logic [1:0] KIND_LINE   = 2'd2;
   localparam logic [1:0] KIND_PROMPT = 2'd3;

   localparam logic [7:0] T_IAC  = 8'd255;
   localparam logic [7:0] T_DONT = 8'd254;
   localparam logic [7:0] T_DO   = 8'd253;
   localparam logic [7:0] T_WONT = 8'd252;
   localparam logic [7:0] T_WILL = 8'd251;
   localparam logic [7:0] T_SB   = 8'd250;
   localparam logic [7:0] T_SE   = 8'd240;

   localparam logic [7:0] C_BS    = 8'd8;
   localparam logic [7:0] C_DEL   = 8'd127;
   localparam logic [7:0] C_CR    = 8'd13;
   localparam logic [7:0] C_LF    = 8'd10;
   localparam logic [7:0] C_SPACE = 8'd32;
   localparam logic [7:0] C_TILDE = 8'd126;
   localparam logic [7:0] C_NUL   = 8'd0;

   typedef enum logic [2:0] {
      MODE_DATA = 3'd0,
      MODE_CMD  = 3'd1,
      MODE_OPT  = 3'd2,
      MODE_SUB  = 3'd3,
      MODE_SUBI = 3'd4
   } parse_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NEG_IAC,
      ST_NEG_VERB,
      ST_NEG_OPT,
      ST_ECHO_CR,
      ST_ECHO_LF,
      ST_LINE,
      ST_PROMPT
   } state_type;

endpackage

@@ src/tlip_line_ram.sv @@
// line buffer memory, one write port and one read port with registered read data
// uses tlip_pkg
module tlip_line_ram
   import tlip_pkg::*;
#(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/telnet_line_input_parser.sv @@
// Telnet line input parser. One request is taken per cycle while the block is idle; a
// request that causes no response (data byte, command byte, session open) leaves it idle.
// An option refusal holds the request side for three responses (IAC, verb, option), a line
// end for two echo responses plus one response per stored character, or one prompt if the
// line is empty. Responses leave through an output register at one per cycle while
// rsp_ready stays high; line characters stream from a single-port-read line buffer RAM
// whose registered read is issued as the previous response is loaded. The line buffer
// needs no clearing after reset.
// uses tlip_pkg and tlip_line_ram
module telnet_line_input_parser
   import tlip_pkg::*;
#(
   parameter int LINE_MAX = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   localparam int ADDR_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
   localparam int CNT_W  = $clog2(LINE_MAX + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_MAX);

   state_type       state_ff, state_in;
   parse_mode_type  mode_ff, mode_in;
   logic            reply_en_ff, reply_en_in;
   logic [7:0]      reply_ff, reply_in;
   logic [7:0]      opt_ff, opt_in;
   logic            after_cr_ff, after_cr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic            accept;
   logic            out_free;
   logic            load_out;
   rsp_payload_type out_word;
   logic            start_neg;
   logic            start_flush;
   logic            line_done;
   logic [7:0]      v;
   logic            in_cmd_path;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   tlip_line_ram #(
      .DEPTH  (LINE_MAX),
      .ADDR_W (ADDR_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (v),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign v         = req_data.rx_byte;
   assign in_cmd_path = (mode_ff != MODE_DATA) || (v == T_IAC);
   assign line_done = (idx_ff == count_ff);
   assign wr_addr   = count_ff[ADDR_W-1:0];

   // request decode
   always_comb begin
      start_neg   = 1'b0;
      start_flush = 1'b0;
      if (accept && req_data.kind == REQ_BYTE) begin
         if (in_cmd_path) begin
            start_neg = (mode_ff == MODE_OPT) && reply_en_ff;
         end else if (v == C_CR || v == C_LF) begin
            start_flush = !(v == C_LF && after_cr_ff);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_neg) begin
               state_in = ST_NEG_IAC;
            end else if (start_flush) begin
               state_in = ST_ECHO_CR;
            end
         end
         ST_NEG_IAC:  if (out_free) state_in = ST_NEG_VERB;
         ST_NEG_VERB: if (out_free) state_in = ST_NEG_OPT;
         ST_NEG_OPT:  if (out_free) state_in = ST_IDLE;
         ST_ECHO_CR:  if (out_free) state_in = ST_ECHO_LF;
         ST_ECHO_LF: begin
            if (out_free) begin
               state_in = (count_ff != '0) ? ST_LINE : ST_PROMPT;
            end
         end
         ST_LINE:   if (out_free && line_done) state_in = ST_IDLE;
         ST_PROMPT: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // response generation and buffer reads
   always_comb begin
      load_out = 1'b0;
      out_word = '{out_kind: KIND_NEG, out_byte: C_NUL, last: 1'b0};
      rd_en    = 1'b0;
      rd_addr  = '0;
      unique case (state_ff)
         ST_IDLE: ;
         ST_NEG_IAC: begin
            load_out = out_free;
            out_word = '{out_kind: KIND_NEG, out_byte: T_IAC, last: 1'b0};
         end
         ST_NEG_VERB: begin
            load_out = out_free;
            out_word = '{out_kind: KIND_NEG, out_byte: reply_ff, last: 1'b0};
         end
         ST_NEG_OPT: begin
            load_out = out_free;
            out_word = '{out_kind: KIND_NEG, out_byte: opt_ff, last: 1'b1};
         end
         ST_ECHO_CR: begin
            load_out = out_free;
            out_word = '{out_kind: KIND_ECHO, out_byte: C_CR, last: 1'b0};
         end
         ST_ECHO_LF: begin
            load_out = out_free;
            out_word = '{out_kind: KIND_ECHO, out_byte: C_LF, last: 1'b0};
            rd_en    = out_free && (count_ff != '0);
         end
         ST_LINE: begin
            load_out = out_free;
            out_word = '{out_kind: KIND_LINE, out_byte: rd_data, last: line_done};
            rd_en    = out_free && !line_done;
            rd_addr  = idx_ff[ADDR_W-1:0];
         end
         ST_PROMPT: begin
            load_out = out_free;
            out_word = '{out_kind: KIND_PROMPT, out_byte: C_NUL, last: 1'b1};
         end
         default: ;
      endcase
   end

   // parser and line state update
   always_comb begin
      mode_in     = mode_ff;
      reply_en_in = reply_en_ff;
      reply_in    = reply_ff;
      opt_in      = opt_ff;
      after_cr_in = after_cr_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      wr_en       = 1'b0;
      if (accept) begin
         if (req_data.kind == REQ_OPEN) begin
            mode_in     = MODE_DATA;
            reply_en_in = 1'b0;
            after_cr_in = 1'b0;
            count_in    = '0;
         end else if (in_cmd_path) begin
            unique case (mode_ff)
               MODE_CMD: begin
                  if (v == T_WILL || v == T_WONT || v == T_DO || v == T_DONT) begin
                     mode_in     = MODE_OPT;
                     reply_en_in = (v == T_WILL) || (v == T_DO);
                     reply_in    = (v == T_WILL) ? T_DONT : T_WONT;
                  end else if (v == T_SB) begin
                     mode_in = MODE_SUB;
                  end else begin
                     mode_in = MODE_DATA;
                  end
               end
               MODE_OPT: begin
                  opt_in  = v;
                  mode_in = MODE_DATA;
               end
               MODE_SUB:  if (v == T_IAC) mode_in = MODE_SUBI;
               MODE_SUBI: mode_in = (v == T_SE) ? MODE_DATA : MODE_SUB;
               default:   if (v == T_IAC) mode_in = MODE_CMD;
            endcase
         end else if (v == C_BS || v == C_DEL) begin
            if (count_ff != '0) count_in = count_ff - 1'b1;
            after_cr_in = 1'b0;
         end else if (v == C_CR || v == C_LF) begin
            if (v == C_LF && after_cr_ff) begin
               after_cr_in = 1'b0;
            end else begin
               after_cr_in = (v == C_CR);
            end
         end else begin
            after_cr_in = 1'b0;
            if (v >= C_SPACE && v <= C_TILDE && count_ff < CNT_MAX) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
      end
      if (state_ff == ST_ECHO_LF && out_free) begin
         idx_in = CNT_W'(1);
      end
      if (state_ff == ST_LINE && out_free) begin
         if (line_done) begin
            count_in = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_in       = out_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_DATA;
         reply_en_ff  <= 1'b0;
         after_cr_ff  <= 1'b0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         reply_en_ff  <= reply_en_in;
         after_cr_ff  <= after_cr_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      reply_ff <= reply_in;
      opt_ff   <= opt_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("line count above buffer size");

   a_line_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LINE |-> idx_ff != '0 && idx_ff <= count_ff)
      else $error("line readout index out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> !rsp_valid_ff || rsp_ready)
      else $error("response overwritten before delivery");

   a_prompt_empty: assert property (@(posedge clock) disable iff (reset)
      load_out && out_word.out_kind == KIND_PROMPT |-> count_ff == '0)
      else $error("prompt issued with a nonempty line");

   a_line_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LINE && out_free && line_done |=> count_ff == '0 && state_ff == ST_IDLE)
      else $error("line not emptied after readout");

endmodule
